/* hw/rtl/stfp_pkg.sv */
// Shared constants, command/status types and ramp arithmetic constants
// for the stepper trapezoid frame planner. No dependencies.
package stfp_pkg;

  localparam int RAMP_ORDER = 10;

  localparam int RATE_W   = 12;
  localparam int STEP_W   = 20;
  localparam int FRAME_W  = 21;
  localparam int CRUISE_W = 20;
  localparam int SUM_W    = STEP_W;

  localparam int PEAK_W  = $clog2(RAMP_ORDER + 1);
  localparam int RAMP_AW = (RAMP_ORDER > 1) ? $clog2(RAMP_ORDER) : 1;

  // ramp entry = min_rate + d*(2i+1)/RAMP_DEN via a rounded-up reciprocal multiply
  localparam int RAMP_DEN = 2 * RAMP_ORDER;
  localparam int NUM_W    = $clog2(((1 << RATE_W) - 1) * (2 * RAMP_ORDER - 1) + 1);
  localparam int RECIP_SH = NUM_W + $clog2(RAMP_DEN);
  localparam int RECIP_W  = NUM_W + 1;
  localparam int RECIP    = ((1 << RECIP_SH) + RAMP_DEN - 1) / RAMP_DEN;
  localparam int PROD_W   = NUM_W + RECIP_W;

  localparam int DIV_CNT_W = $clog2(STEP_W);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE = 1'b1;

  localparam logic [RATE_W-1:0] MIN_RATE_RST = 12'd100;
  localparam logic [RATE_W-1:0] MAX_RATE_RST = 12'd1000;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef struct packed {
    logic capture;
    logic ramp_mul;
    logic ramp_acc;
    logic decide;
    logic div_step;
    logic commit;
    logic tick_sel;
    logic tick_rd;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic ramp_last;
    logic trap_now;
    logic div_last;
  } dp_stat_t;

endpackage

/* hw/rtl/stfp_in_if.sv */
// Request channel into the frame planner: valid/ready plus action and step count.
// Depends on stfp_pkg.
interface stfp_in_if;
  import stfp_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [STEP_W-1:0] step_total;

  modport source (output valid, output action, output step_total, input ready);
  modport sink   (input valid, input action, input step_total, output ready);
endinterface

/* hw/rtl/stfp_out_if.sv */
// Result channel out of the frame planner: valid/ready plus frame payload.
// Depends on stfp_pkg.
interface stfp_out_if;
  import stfp_pkg::*;

  logic               valid;
  logic               ready;
  logic [RATE_W-1:0]  frame_pulses;
  logic [FRAME_W-1:0] frame_total;
  logic               frame_valid;
  logic               last_frame;

  modport source (output valid, output frame_pulses, output frame_total,
                  output frame_valid, output last_frame, input ready);
  modport sink   (input valid, input frame_pulses, input frame_total,
                  input frame_valid, input last_frame, output ready);
endinterface

/* hw/rtl/stfp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stfp_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 10,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/stfp_ctrl.sv */
// Controller state machine of the frame planner: sequences ramp build,
// division, commit and frame ticks. Depends on stfp_pkg.
module stfp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_action,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  input  stfp_pkg::dp_stat_t stat,
  output stfp_pkg::dp_cmd_t  cmd
);
  import stfp_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_RAMP_MUL = 9'b000000010,
    ST_RAMP_ACC = 9'b000000100,
    ST_DECIDE   = 9'b000001000,
    ST_DIVIDE   = 9'b000010000,
    ST_COMMIT   = 9'b000100000,
    ST_TICK_SEL = 9'b001000000,
    ST_TICK_RD  = 9'b010000000,
    ST_RESULT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_action == ACT_START) ? ST_RAMP_MUL : ST_TICK_SEL;
        end
      end
      ST_RAMP_MUL: begin
        cmd.ramp_mul = 1'b1;
        state_nxt    = ST_RAMP_ACC;
      end
      ST_RAMP_ACC: begin
        cmd.ramp_acc = 1'b1;
        state_nxt    = stat.ramp_last ? ST_DECIDE : ST_RAMP_MUL;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = stat.trap_now ? ST_DIVIDE : ST_COMMIT;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_RESULT;
      end
      ST_TICK_SEL: begin
        cmd.tick_sel = 1'b1;
        state_nxt    = ST_TICK_RD;
      end
      ST_TICK_RD: begin
        cmd.tick_rd = 1'b1;
        state_nxt   = ST_RESULT;
      end
      ST_RESULT: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/stfp_dp.sv */
// Datapath of the frame planner: config registers, ramp generator, serial
// divider, move plan and frame selection. Depends on stfp_pkg and stfp_ram.
module stfp_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [stfp_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [stfp_pkg::RATE_W-1:0]        cfg_wdata,
  input  logic [stfp_pkg::STEP_W-1:0]        in_step_total,
  input  stfp_pkg::dp_cmd_t                  cmd,
  output stfp_pkg::dp_stat_t                 stat,
  output logic [stfp_pkg::RATE_W-1:0]        out_frame_pulses,
  output logic [stfp_pkg::FRAME_W-1:0]       out_frame_total,
  output logic                               out_frame_valid,
  output logic                               out_last_frame
);
  import stfp_pkg::*;

  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_RAMP,
    SRC_FULL,
    SRC_TAIL,
    SRC_MLOW,
    SRC_MHIGH
  } src_t;

  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  // config
  logic [RATE_W-1:0] min_rate_r, max_rate_r;
  logic [RATE_W-1:0] full_rate, delta;

  // planning scratch
  logic [STEP_W-1:0]    steps_r;
  logic [RAMP_AW-1:0]   idx_r;
  logic [NUM_W-1:0]     num_r;
  logic [PROD_W-1:0]    prod_r;
  logic [SUM_W-1:0]     sum_r;
  logic [STEP_W-1:0]    rest_r;
  logic                 found_r;
  logic [PEAK_W-1:0]    pk_r;
  logic                 trap_r;
  logic [STEP_W-1:0]    quo_r;
  logic [RATE_W-1:0]    rem_r;
  logic [DIV_CNT_W-1:0] dcnt_r;

  // move plan
  logic                 kind_r;
  logic [FRAME_W-1:0]   frame_idx_r;
  logic [FRAME_W-1:0]   frames_planned_r;
  logic [CRUISE_W-1:0]  cruise_r;
  logic [RATE_W-1:0]    tail_r;
  logic [PEAK_W-1:0]    peak_r;
  logic [RATE_W-1:0]    mid_low_r, mid_high_r;
  logic                 active_r;

  // tick and result
  src_t                 src_r, sel;
  logic                 ok_r, last_r;
  logic [RATE_W-1:0]    res_pulses_r;
  logic                 res_valid_r, res_last_r;
  logic [RATE_W-1:0]    out_pulses_r;
  logic [FRAME_W-1:0]   out_total_r;
  logic                 out_valid_r, out_last_r;

  logic [RATE_W-1:0]    entry;
  logic [RATE_W:0]      entry2;
  logic [FRAME_W-1:0]   ramp_sum;
  logic [RATE_W:0]      rem_sh;
  logic [RATE_W:0]      rem_diff;
  logic [FRAME_W-1:0]   addr;
  logic [FRAME_W:0]     kx, k1, cruise_end, pw, p2;
  logic                 tick_ok, tick_last;
  logic [RATE_W-1:0]    ram_rdata;
  logic [RATE_W-1:0]    pulses;

  assign full_rate = (max_rate_r == '0) ? RATE_W'(1) : max_rate_r;
  assign delta     = (full_rate > min_rate_r) ? full_rate - min_rate_r : '0;

  assign entry    = RATE_W'(prod_r >> RECIP_SH) + min_rate_r;
  assign entry2   = {entry, 1'b0};
  assign ramp_sum = {sum_r, 1'b0};
  assign rem_sh   = {rem_r, quo_r[STEP_W-1]};
  assign rem_diff = rem_sh - {1'b0, full_rate};

  assign stat.ramp_last = (idx_r == RAMP_AW'(RAMP_ORDER - 1));
  assign stat.trap_now  = ({1'b0, steps_r} >= ramp_sum);
  assign stat.div_last  = (dcnt_r == DIV_CNT_W'(STEP_W - 1));

  // frame source selection
  assign kx         = {1'b0, frame_idx_r};
  assign k1         = kx + 1'b1;
  assign cruise_end = (FRAME_W + 1)'(RAMP_ORDER) + (FRAME_W + 1)'(cruise_r);
  assign pw         = (FRAME_W + 1)'(peak_r);
  assign p2         = pw << 1;
  assign tick_ok    = active_r && (frame_idx_r < frames_planned_r);
  assign tick_last  = (k1 >= {1'b0, frames_planned_r});

  always_comb begin
    sel  = SRC_ZERO;
    addr = '0;
    if (!kind_r) begin
      if (kx < (FRAME_W + 1)'(RAMP_ORDER)) begin
        sel  = SRC_RAMP;
        addr = frame_idx_r;
      end else if (kx < cruise_end) begin
        sel = SRC_FULL;
      end else if (kx == cruise_end) begin
        sel = SRC_TAIL;
      end else if (frame_idx_r < frames_planned_r) begin
        sel  = SRC_RAMP;
        addr = frames_planned_r - FRAME_W'(1) - frame_idx_r;
      end
    end else if (peak_r != '0) begin
      if (k1 < pw) begin
        sel  = SRC_RAMP;
        addr = frame_idx_r;
      end else if (k1 == pw) begin
        sel = SRC_MLOW;
      end else if (kx == pw) begin
        sel = SRC_MHIGH;
      end else if (kx < p2) begin
        sel  = SRC_RAMP;
        addr = FRAME_W'(p2 - (FRAME_W + 1)'(1) - kx);
      end
    end
    if (sel == SRC_RAMP && addr >= FRAME_W'(RAMP_ORDER)) begin
      sel = SRC_ZERO;
    end
  end

  always_comb begin
    case (src_r)
      SRC_RAMP:  pulses = ram_rdata;
      SRC_FULL:  pulses = full_rate;
      SRC_TAIL:  pulses = tail_r;
      SRC_MLOW:  pulses = mid_low_r;
      SRC_MHIGH: pulses = mid_high_r;
      default:   pulses = '0;
    endcase
  end

  stfp_ram #(
    .WIDTH (RATE_W),
    .DEPTH (RAMP_ORDER)
  ) u_ramp_ram (
    .clk   (clk),
    .we    (cmd.ramp_acc),
    .waddr (idx_r),
    .wdata (entry),
    .raddr (addr[RAMP_AW-1:0]),
    .rdata (ram_rdata)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_rate_r <= MIN_RATE_RST;
      max_rate_r <= MAX_RATE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MIN_RATE: min_rate_r <= cfg_wdata;
        CFG_MAX_RATE: max_rate_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ramp build, triangle walk and divider (scratch, no reset)
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      steps_r <= in_step_total;
      rest_r  <= in_step_total;
      num_r   <= NUM_W'(delta);
      idx_r   <= '0;
      sum_r   <= '0;
      found_r <= 1'b0;
      pk_r    <= PEAK_W'(RAMP_ORDER);
    end
    if (cmd.ramp_mul) begin
      prod_r <= num_r * RECIP_C;
    end
    if (cmd.ramp_acc) begin
      sum_r <= sum_r + SUM_W'(entry);
      if (!found_r) begin
        if (rest_r < STEP_W'(entry2)) begin
          found_r <= 1'b1;
          pk_r    <= PEAK_W'(idx_r) + PEAK_W'(1);
        end else begin
          rest_r <= rest_r - STEP_W'(entry2);
        end
      end
      num_r <= num_r + NUM_W'({delta, 1'b0});
      idx_r <= idx_r + RAMP_AW'(1);
    end
    if (cmd.decide) begin
      trap_r <= stat.trap_now;
      quo_r  <= steps_r - ramp_sum[STEP_W-1:0];
      rem_r  <= '0;
      dcnt_r <= '0;
    end
    if (cmd.div_step) begin
      if (!rem_diff[RATE_W]) begin
        rem_r <= rem_diff[RATE_W-1:0];
        quo_r <= {quo_r[STEP_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[RATE_W-1:0];
        quo_r <= {quo_r[STEP_W-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r + DIV_CNT_W'(1);
    end
    if (cmd.tick_sel) begin
      src_r  <= sel;
      ok_r   <= tick_ok;
      last_r <= tick_last;
    end
  end

  // move plan and per-item result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r           <= 1'b0;
      frame_idx_r      <= '0;
      frames_planned_r <= '0;
      cruise_r         <= '0;
      tail_r           <= '0;
      peak_r           <= '0;
      mid_low_r        <= '0;
      mid_high_r       <= '0;
      active_r         <= 1'b0;
    end else begin
      if (cmd.commit) begin
        frame_idx_r <= '0;
        active_r    <= 1'b1;
        if (trap_r) begin
          kind_r           <= 1'b0;
          cruise_r         <= quo_r;
          tail_r           <= rem_r;
          frames_planned_r <= FRAME_W'(2 * RAMP_ORDER + 1) + FRAME_W'(quo_r);
          peak_r           <= '0;
          mid_low_r        <= '0;
          mid_high_r       <= '0;
        end else begin
          kind_r           <= 1'b1;
          peak_r           <= pk_r;
          mid_low_r        <= RATE_W'(rest_r >> 1);
          mid_high_r       <= RATE_W'(rest_r - (rest_r >> 1));
          frames_planned_r <= FRAME_W'({pk_r, 1'b0});
          cruise_r         <= '0;
          tail_r           <= '0;
        end
      end
      if (cmd.tick_rd) begin
        if (ok_r) begin
          frame_idx_r <= FRAME_W'(k1);
          if (last_r) begin
            active_r <= 1'b0;
          end
        end else begin
          active_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_pulses_r <= '0;
      res_valid_r  <= 1'b0;
      res_last_r   <= 1'b0;
    end
    if (cmd.tick_rd) begin
      res_pulses_r <= ok_r ? pulses : '0;
      res_valid_r  <= ok_r;
      res_last_r   <= ok_r && last_r;
    end
    if (cmd.out_load) begin
      out_pulses_r <= res_pulses_r;
      out_total_r  <= frames_planned_r;
      out_valid_r  <= res_valid_r;
      out_last_r   <= res_last_r;
    end
  end

  assign out_frame_pulses = out_pulses_r;
  assign out_frame_total  = out_total_r;
  assign out_frame_valid  = out_valid_r;
  assign out_last_frame   = out_last_r;

endmodule

/* hw/rtl/stepper_trapezoid_frame_planner.sv */
// Top level of the stepper trapezoid frame planner.
// Depends on stfp_pkg, stfp_in_if, stfp_out_if, stfp_ctrl, stfp_dp.
//  - in_chan (valid/ready) takes requests: action start (0) plans a move of
//    step_total steps, action tick (1) asks for the next frame.
//  - out_chan (valid/ready) returns exactly one result per request:
//    frame_pulses, frame_total, frame_valid, last_frame.
//  - cfg_we/cfg_idx/cfg_wdata write min_rate (index 0) and max_rate (index 1);
//    user must write only while no request is in flight; block doesn't check
// One request at a time (in_chan.ready is high only when idle):
//  - start: ramp build (multiply, then accumulate per entry), decide, the
//    bit-serial divider for a trapezoid only, commit, result load.
//  - tick: select, ramp RAM read, result load.
//  - the next request is taken the cycle after the result loads; the result
//    load waits while a stalled receiver still holds the output register.
// Reset (synchronous, rst_n low) restores min_rate 100, max_rate 1000 and
// clears the plan: ticks return zero frames until a move is started.
// A stalled out_chan holds its payload; the block takes one more request and
// parks its result until the output register frees up.
module stepper_trapezoid_frame_planner (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [stfp_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [stfp_pkg::RATE_W-1:0]    cfg_wdata,
  stfp_in_if.sink                        in_chan,
  stfp_out_if.source                     out_chan
);
  import stfp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  stfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_action (in_chan.action),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  stfp_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata),
    .in_step_total    (in_chan.step_total),
    .cmd              (cmd),
    .stat             (stat),
    .out_frame_pulses (out_chan.frame_pulses),
    .out_frame_total  (out_chan.frame_total),
    .out_frame_valid  (out_chan.frame_valid),
    .out_last_frame   (out_chan.last_frame)
  );

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for stepper_trapezoid_frame_planner: a scoreboard predicts
// each frame of every planned move, and the result channel is checked against it.
// Depends on stfp_pkg, stfp_in_if, stfp_out_if and the planner RTL.
module testbench;
  import stfp_pkg::*;

  localparam int unsigned MASK_RATE   = (1 << RATE_W) - 1;
  localparam int unsigned MASK_STEP   = (1 << STEP_W) - 1;
  localparam int unsigned MASK_FRAME  = (1 << FRAME_W) - 1;
  localparam int unsigned MASK_CRUISE = (1 << CRUISE_W) - 1;
  localparam int unsigned MASK_PEAK   = 15;

  localparam int REQ_TARGET    = 1950;
  localparam int PHASES        = 8;
  localparam int TICK_CAP      = 48;     // long cruises are cut short by a new start
  localparam int SETTLE_CYCLES = 60;     // above the start latency
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [RATE_W-1:0]  pulses;
    logic [FRAME_W-1:0] total;
    logic               valid;
    logic               last;
  } frame_res_t;

  // Predicts the planner from its own copy of the rates and the plan, and holds
  // the expected result of every accepted request until it comes back.
  class frame_plan_scoreboard;
    int unsigned lo_rate, hi_rate;
    int unsigned ramp_lvl [RAMP_ORDER];
    int unsigned twice_ramp, frame_count, next_frame;
    int unsigned cruise_cnt, tail_cnt, peak, mid_a, mid_b;
    bit          is_triangle, moving;
    frame_res_t  pending [$];
    int unsigned n_errors, n_checked;

    function new();
      lo_rate = MIN_RATE_RST;
      hi_rate = MAX_RATE_RST;
      foreach (ramp_lvl[i]) ramp_lvl[i] = 0;
    endfunction

    function void set_rate(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] val);
      if (idx == CFG_MIN_RATE) lo_rate = val;
      else if (idx == CFG_MAX_RATE) hi_rate = val;
    endfunction

    // zero max rate behaves as one, both as cruise rate and divisor
    function int unsigned top_rate();
      return (hi_rate == 0) ? 1 : hi_rate;
    endfunction

    function int unsigned ramp_level(int unsigned i);
      int unsigned span;
      span = (top_rate() > lo_rate) ? top_rate() - lo_rate : 0;
      return ((span * (2 * i + 1)) / (2 * RAMP_ORDER) + lo_rate) & MASK_RATE;
    endfunction

    // steps taken by a full ramp up plus ramp down at the current rates
    function int unsigned ramp_span_steps();
      int unsigned acc;
      acc = 0;
      for (int i = 0; i < RAMP_ORDER; i++) acc += ramp_level(i);
      return (2 * acc) & MASK_FRAME;
    endfunction

    function int unsigned ramp_entry(int unsigned i);
      return (i < RAMP_ORDER) ? ramp_lvl[i] : 0;
    endfunction

    function void build_plan(int unsigned steps);
      int unsigned f, rest, p;
      f = top_rate();
      for (int i = 0; i < RAMP_ORDER; i++) ramp_lvl[i] = ramp_level(i);
      twice_ramp = ramp_span_steps();
      if (steps >= twice_ramp) begin
        is_triangle = 1'b0;
        cruise_cnt  = ((steps - twice_ramp) / f) & MASK_CRUISE;
        tail_cnt    = ((steps - twice_ramp) % f) & MASK_RATE;
        frame_count = (2 * RAMP_ORDER + cruise_cnt + 1) & MASK_FRAME;
        peak  = 0;
        mid_a = 0;
        mid_b = 0;
      end else begin
        rest = steps;
        p    = RAMP_ORDER;
        for (int i = 0; i < RAMP_ORDER; i++) begin
          if (rest < 2 * ramp_lvl[i]) begin
            p = i + 1;
            break;
          end
          rest -= 2 * ramp_lvl[i];
        end
        is_triangle = 1'b1;
        peak        = p & MASK_PEAK;
        mid_a       = (rest / 2) & MASK_RATE;
        mid_b       = (rest - rest / 2) & MASK_RATE;
        frame_count = (2 * p) & MASK_FRAME;
        cruise_cnt  = 0;
        tail_cnt    = 0;
      end
      next_frame = 0;
      moving     = 1'b1;
    endfunction

    function int unsigned pulses_for_frame(int unsigned k);
      if (!is_triangle) begin
        if (k < RAMP_ORDER) return ramp_entry(k);
        if (k < RAMP_ORDER + cruise_cnt) return top_rate();
        if (k == RAMP_ORDER + cruise_cnt) return tail_cnt;
        if (k < frame_count) return ramp_entry(frame_count - 1 - k);
        return 0;
      end
      if (peak == 0) return 0;
      if (k + 1 < peak) return ramp_entry(k);
      if (k + 1 == peak) return mid_a;
      if (k == peak) return mid_b;
      if (k < 2 * peak) return ramp_entry(2 * peak - 1 - k);
      return 0;
    endfunction

    function void note_request(logic action, logic [STEP_W-1:0] steps);
      frame_res_t want;
      want = '0;
      if (action == ACT_START) begin
        build_plan(steps);
      end else if (moving && next_frame < frame_count) begin
        want.pulses = RATE_W'(pulses_for_frame(next_frame));
        want.valid  = 1'b1;
        if (next_frame + 1 >= frame_count) begin
          want.last = 1'b1;
          moving    = 1'b0;
        end
        next_frame = (next_frame + 1) & MASK_FRAME;
      end else begin
        moving = 1'b0;
      end
      want.total = FRAME_W'(frame_count);
      pending.push_back(want);
    endfunction

    function void check_frame(frame_res_t got);
      frame_res_t want;
      n_checked++;
      if (pending.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result: pulses %0d total %0d valid %0b last %0b",
                 $time, got.pulses, got.total, got.valid, got.last);
        return;
      end
      want = pending.pop_front();
      if (got.pulses !== want.pulses) begin
        n_errors++;
        $display("%0t: frame_pulses expected %0d actual %0d", $time, want.pulses, got.pulses);
      end
      if (got.total !== want.total) begin
        n_errors++;
        $display("%0t: frame_total expected %0d actual %0d", $time, want.total, got.total);
      end
      if (got.valid !== want.valid) begin
        n_errors++;
        $display("%0t: frame_valid expected %0b actual %0b", $time, want.valid, got.valid);
      end
      if (got.last !== want.last) begin
        n_errors++;
        $display("%0t: last_frame expected %0b actual %0b", $time, want.last, got.last);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [RATE_W-1:0]    cfg_wdata;

  stfp_in_if  in_chan ();
  stfp_out_if out_chan ();

  stepper_trapezoid_frame_planner u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  frame_plan_scoreboard sb;

  bit          calm = 1'b0;   // no idling on either side while set
  int unsigned n_cycles = 0;
  int unsigned n_starts = 0;
  int unsigned n_ticks  = 0;

  // rate settings per phase: defaults, widest ramp, both at top, full rate
  // under min rate, flat ramp, zero max rate, zero min rate, an odd mix
  int unsigned phase_lo [PHASES] = '{100,  1,    4095, 4095, 1, 100, 0,   37};
  int unsigned phase_hi [PHASES] = '{1000, 4095, 4095, 1,    1, 0,   300, 2500};

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
               sb.pending.size());
      $display("status: fail");
      $finish;
    end
  end

  // Result side: check what was taken at this edge, then pick ready for the
  // next one. Stalls hold the planner's result load and its output register.
  always @(posedge clk) begin : result_sink
    frame_res_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.pulses = out_chan.frame_pulses;
      got.total  = out_chan.frame_total;
      got.valid  = out_chan.frame_valid;
      got.last   = out_chan.last_frame;
      sb.check_frame(got);
    end
    out_chan.ready <= calm || ($urandom_range(99) >= 25);
  end

  // Register writes happen only while no request is in flight.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.set_rate(idx, val);
  endtask

  // One request: optional idle cycles, then hold valid until the planner
  // takes it. Valid stays high straight into the next request when no gap.
  task automatic send_request(logic act, logic [STEP_W-1:0] steps);
    while (!calm && $urandom_range(99) < 25) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.action     <= act;
    in_chan.step_total <= steps;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_request(act, steps);
    if (act == ACT_START) n_starts++;
    else n_ticks++;
  endtask

  // Hold the sender until every result is back, then let the planner settle.
  task automatic wait_idle(int unsigned settle);
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Step counts aimed at the interesting places for the current rates:
  // triangles, the trapezoid boundary, short cruises, empty remainders.
  function automatic logic [STEP_W-1:0] pick_steps();
    int unsigned rs, f, s, roll;
    rs   = sb.ramp_span_steps();
    f    = sb.top_rate();
    roll = $urandom_range(99);
    if (roll < 30) s = (rs > 0) ? $urandom_range(rs - 1) : 0;
    else if (roll < 38) s = (rs > 0) ? rs - $urandom_range(1) : rs;
    else if (roll < 70) s = rs + $urandom_range(8 * f);
    else if (roll < 85) s = rs + f * $urandom_range(6);
    else s = $urandom & MASK_STEP;
    if (s > MASK_STEP) s = MASK_STEP;
    return STEP_W'(s);
  endfunction

  // A move: start, ticks to the last frame (or an early abandon), and now
  // and then a tick or two past the end.
  task automatic run_move();
    int unsigned cap, n;
    send_request(ACT_START, pick_steps());
    cap = ($urandom_range(9) == 0) ? $urandom_range(5) : TICK_CAP;
    n   = 0;
    while (sb.moving && n < cap) begin
      send_request(ACT_TICK, STEP_W'($urandom));
      n++;
    end
    if (!sb.moving) repeat ($urandom_range(2)) send_request(ACT_TICK, STEP_W'($urandom));
  endtask

  initial begin
    int unsigned rs, per_phase, phase_end, roll;
    sb = new();
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= CFG_MIN_RATE;
    cfg_wdata          <= '0;
    in_chan.valid      <= 1'b0;
    in_chan.action     <= ACT_START;
    in_chan.step_total <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset rates.
    rs = sb.ramp_span_steps();
    send_request(ACT_TICK, STEP_W'(MASK_STEP));     // tick before any move
    send_request(ACT_START, '0);                    // smallest triangle
    repeat (3) send_request(ACT_TICK, '0);          // two frames, then one past the end
    send_request(ACT_START, STEP_W'(rs));           // exactly a full ramp: no cruise
    repeat (12) send_request(ACT_TICK, STEP_W'($urandom)); // reaches the empty remainder
    send_request(ACT_START, STEP_W'(MASK_STEP));    // restart mid-move, longest move
    repeat (2) send_request(ACT_TICK, STEP_W'($urandom));
    send_request(ACT_START, STEP_W'(rs - 1));       // just short of a trapezoid
    repeat (2) send_request(ACT_TICK, STEP_W'($urandom));
    wait_idle(SETTLE_CYCLES);

    // Random part, one phase per rate setting. A move left open at a phase
    // change keeps its plan and goes on with the new full rate.
    per_phase = REQ_TARGET / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph == 3);
      if (ph % 2 == 1) begin
        write_reg(CFG_MAX_RATE, RATE_W'(phase_hi[ph]));
        write_reg(CFG_MIN_RATE, RATE_W'(phase_lo[ph]));
      end else begin
        write_reg(CFG_MIN_RATE, RATE_W'(phase_lo[ph]));
        write_reg(CFG_MAX_RATE, RATE_W'(phase_hi[ph]));
      end
      phase_end = n_starts + n_ticks + per_phase;
      repeat ($urandom_range(3, 1)) send_request(ACT_TICK, STEP_W'($urandom));
      while (n_starts + n_ticks < phase_end) begin
        roll = $urandom_range(99);
        if (roll < 85) run_move();
        else if (roll < 95) send_request(ACT_TICK, STEP_W'($urandom));
        else if (roll < 98) send_request(ACT_START, STEP_W'($urandom));
        else wait_idle(0);
      end
      wait_idle(SETTLE_CYCLES);
    end
    calm = 1'b0;

    $display("%0d requests (%0d move starts, %0d frame ticks) over %0d rate settings",
             n_starts + n_ticks, n_starts, n_ticks, PHASES + 1);
    $display("%0d results compared, %0d mismatches", sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* stepper_trapezoid_frame_planner.f */
hw/rtl/stfp_pkg.sv
hw/rtl/stfp_in_if.sv
hw/rtl/stfp_out_if.sv
hw/rtl/stfp_ram.sv
hw/rtl/stfp_ctrl.sv
hw/rtl/stfp_dp.sv
hw/rtl/stepper_trapezoid_frame_planner.sv
test/testbench.sv
